// File: src/alv_pkg.sv
// alv_pkg: shared constants, types and state codes of the loudness leveler
// no dependencies; imported by alv_mult, alv_div and audio_loudness_leveler
package alv_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 18;
  localparam int unsigned LEVEL_W  = 19;
  localparam int unsigned CFG_W    = 8;

  localparam logic [LEVEL_W-1:0] TARGET_LEVEL = 19'd2500;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR  = 19'd512;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN   = 18'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_MAX     = 18'd160000;
  localparam int unsigned        DECAY_SHIFT  = 11;
  localparam logic [16:0]        PEAK_LIMIT   = 17'd8192;

  // multiplier: two gain bits per step
  localparam int unsigned MUL_STEPS = GAIN_W / 2;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned ACC_W     = SAMPLE_W + 3;

  // divider: quotient below 2^18 since the level is at least 512
  localparam logic [26:0] DIVIDEND  = 27'd81920000;
  localparam int unsigned DIV_STEPS = GAIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

// File: src/alv_mult.sv
// alv_mult: radix-4 serial multiplier, signed sample times unsigned Q15 gain
// two gain bits per cycle, yields bits 30:15 of the product; uses alv_pkg
module alv_mult (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [alv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [alv_pkg::GAIN_W-1:0]     gain_i,
  output logic signed [alv_pkg::SAMPLE_W-1:0] scaled_o,
  output alv_pkg::unit_stat_t            stat_o
);
  import alv_pkg::*;

  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [GAIN_W-1:0]          low_q, low_d;
  logic signed [SAMPLE_W-1:0] mcand_q;
  logic [MUL_CNT_W-1:0]       cnt_q;
  logic                       busy_q, done_q;

  logic signed [ACC_W-1:0] m_ext, digit_prod, sum;

  always_comb begin
    m_ext = ACC_W'(mcand_q);
    case (low_q[1:0])
      2'd0:    digit_prod = '0;
      2'd1:    digit_prod = m_ext;
      2'd2:    digit_prod = m_ext <<< 1;
      2'd3:    digit_prod = m_ext + (m_ext <<< 1);
      default: digit_prod = '0;
    endcase
    sum   = acc_q + digit_prod;
    acc_d = sum >>> 2;
    low_d = {sum[1:0], low_q[GAIN_W-1:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      low_q   <= gain_i;
      mcand_q <= sample_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      low_q <= low_d;
    end
  end

  // product = acc * 2^18 + low, keep bits 30:15
  assign scaled_o = {acc_q[12:0], low_q[GAIN_W-1:GAIN_W-3]};
  assign stat_o   = '{busy: busy_q, done: done_q};

endmodule

// File: src/alv_div.sv
// alv_div: restoring serial divider, one quotient bit per cycle
// computes (2500 << 15) / level for a level of at least 512; uses alv_pkg
module alv_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alv_pkg::LEVEL_W-1:0] divisor_i,
  output logic [alv_pkg::GAIN_W-1:0]  quotient_o,
  output alv_pkg::unit_stat_t         stat_o
);
  import alv_pkg::*;

  logic [LEVEL_W-1:0]   rem_q, dvs_q;
  logic [GAIN_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [LEVEL_W:0] trial, diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[GAIN_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits are already below any legal divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= LEVEL_W'(DIVIDEND[26:GAIN_W]);
      quo_q <= DIVIDEND[GAIN_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
      quo_q <= {quo_q[GAIN_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign stat_o     = '{busy: busy_q, done: done_q};

endmodule

// File: src/audio_loudness_leveler.sv
// audio_loudness_leveler: top level, sequencer, level tracker, output register
// depends on alv_pkg, alv_mult and alv_div
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries sample_in_i, update_phase_i
//   and restart_i; one result per transfer leaves on the output channel
//   (out_valid_o / out_stall_i) as sample_out_o and gain_now_o.
//   cfg_valid_i / cfg_ready_o writes loudness_level; ready is always high.
//   path per item, from input transfer to output valid:
//     leveling off: straight to the finish state
//     leveling on, phase nonzero: the radix-4 multiplier, then the finish state
//     leveling on, phase zero: as above, but adds 18 divider steps and a hand-off
//   one item is in work at a time; the input stalls while it runs, so
//   the next transfer is taken only once the sequencer is back in idle.
//   the output register holds a finished result while the receiver stalls,
//   and the next item is already taken and worked on; it waits at the end
//   only if the output register is still full.
//   reset: leveling off, average 2500, gain 32768, output empty.
//   a restart item sets average and gain back before it is processed.
module audio_loudness_leveler #(
  parameter int unsigned PHASE_BITS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [alv_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [alv_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [PHASE_BITS-1:0]               update_phase_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [alv_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [alv_pkg::GAIN_W-1:0]          gain_now_o
);
  import alv_pkg::*;

  state_e                 state_q;
  logic [CFG_W-1:0]       loud_q;
  logic [LEVEL_W-1:0]     avg_q;
  logic [GAIN_W-1:0]      gain_q;
  logic                   out_valid_q;
  logic                   phase_zero_q;
  logic signed [SAMPLE_W-1:0] res_sample_q, out_sample_q;
  logic [GAIN_W-1:0]      out_gain_q;

  logic                   accept, enabled, mul_start, div_start, out_free;
  logic [GAIN_W-1:0]      mul_gain;
  logic signed [SAMPLE_W-1:0] scaled;
  logic [GAIN_W-1:0]      quotient;
  unit_stat_t             mul_stat, div_stat;

  logic [16:0]            mag;
  logic [LEVEL_W-1:0]     mag_w, lvl_raw, lvl;
  logic [30:0]            decay_sum;

  assign enabled     = (loud_q != '0);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mul_gain  = restart_i ? UNITY_GAIN : gain_q;
  assign mul_start = accept && enabled;
  assign div_start = (state_q == ST_MUL) && mul_stat.done && phase_zero_q;

  // magnitude, peak weighting, 1/2048 decay of the average and floor clamp
  always_comb begin
    mag       = scaled[SAMPLE_W-1] ? 17'(-{scaled[SAMPLE_W-1], scaled})
                                   : 17'({scaled[SAMPLE_W-1], scaled});
    mag_w     = (mag >= PEAK_LIMIT) ? LEVEL_W'({mag, 3'b000}) : LEVEL_W'(mag);
    decay_sum = ({12'd0, avg_q} << DECAY_SHIFT) - {12'd0, avg_q} + {12'd0, mag_w};
    lvl_raw   = decay_sum[DECAY_SHIFT +: LEVEL_W];
    lvl       = (lvl_raw < LEVEL_FLOOR) ? LEVEL_FLOOR : lvl_raw;
  end

  alv_mult u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .sample_i (sample_in_i),
    .gain_i   (mul_gain),
    .scaled_o (scaled),
    .stat_o   (mul_stat)
  );

  alv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (lvl),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loud_q      <= '0;
      avg_q       <= TARGET_LEVEL;
      gain_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        loud_q <= cfg_data_i;
      end
      // in the finish state a leaving result is replaced by the next one
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (restart_i) begin
              avg_q  <= TARGET_LEVEL;
              gain_q <= UNITY_GAIN;
            end
            state_q <= enabled ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            if (phase_zero_q) begin
              avg_q   <= lvl;
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            gain_q  <= quotient;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_zero_q <= (update_phase_i == '0);
      res_sample_q <= sample_in_i;
    end
    if ((state_q == ST_MUL) && mul_stat.done) begin
      res_sample_q <= scaled;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_sample_q <= res_sample_q;
      out_gain_q   <= gain_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign gain_now_o   = out_gain_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) gain_q <= GAIN_MAX)
    else $error("gain above its bound");

  assert property (@(posedge clk_i) disable iff (!rst_ni) avg_q >= LEVEL_FLOOR)
    else $error("average below floor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mul_stat.done |-> (state_q == ST_MUL))
    else $error("multiplier done outside multiply phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && !enabled) |=> (state_q == ST_FIN))
    else $error("bypass item did not go straight to output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

endmodule
